@@ rtl/swarm_offset_placer_unit_assert.svh @@
// Assertion macros for the swarm offset placer.
// Each macro expects i_clk and i_rst_n in the scope where it is used.
`ifndef SWARM_OFFSET_PLACER_UNIT_ASSERT_SVH
`define SWARM_OFFSET_PLACER_UNIT_ASSERT_SVH

// Same-cycle implication.
`define SOP_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("swarm offset placer: assertion failed");

// Next-cycle implication.
`define SOP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("swarm offset placer: assertion failed");

`endif

@@ rtl/sop_pkg.sv @@
`default_nettype none

package sop_pkg;

    localparam int POS_W  = 32;
    localparam int MD_W   = 31;
    localparam int MUL_W  = 32;
    localparam int PROD_W = 2 * MUL_W;

    localparam logic [MD_W-1:0] SPACING_RESET = 31'd65536;

    // floor(x / 3) == (x * RECIP3) >> RECIP3_SHIFT for every 32-bit unsigned x.
    localparam logic [MUL_W-1:0] RECIP3       = 32'hAAAA_AAAB;
    localparam int               RECIP3_SHIFT = 33;

    localparam logic signed [POS_W-1:0] OFF_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [POS_W-1:0] OFF_MIN = 32'sh8000_0000;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MD2,
        S_STEP,
        S_INIT,
        S_START,
        S_FETCH,
        S_CHECK,
        S_SQX,
        S_SUM,
        S_FREE,
        S_BLOCKED,
        S_WRITE
    } t_state;

    typedef struct packed {
        logic signed [POS_W-1:0] pos;
        logic signed [POS_W-1:0] off;
    } t_entry;

endpackage

`default_nettype wire

@@ rtl/sop_ifs.sv @@
`default_nettype none

interface sop_in_if
    import sop_pkg::*;
();
    logic                    valid;
    logic                    ready;
    logic signed [POS_W-1:0] y_pos;
    logic                    start_req;

    modport source (output valid, output y_pos, output start_req, input ready);
    modport sink   (input valid, input y_pos, input start_req, output ready);
endinterface

interface sop_out_if
    import sop_pkg::*;
();
    logic                    valid;
    logic                    ready;
    logic signed [POS_W-1:0] x_offset;
    logic                    out_of_order;

    modport source (output valid, output x_offset, output out_of_order, input ready);
    modport sink   (input valid, input x_offset, input out_of_order, output ready);
endinterface

`default_nettype wire

@@ rtl/swarm_offset_placer_unit.sv @@
// Channel   | Dir | Payload                         | Transfer
// ----------+-----+---------------------------------+-------------------
// i_item    | in  | y_pos (s32 Q16.16), start_req   | valid && ready
// o_result  | out | x_offset (s32), out_of_order    | valid && ready
// i_cfg_wr  | in  | spacing (u31 Q16.16)            | i_cfg_wr_en high
//
// After acceptance an item goes through setup (the spacing squared, then a third of the
// spacing as the step), then for every candidate tested each stored point walked is fetched
// and checked, with a squared-distance check for a point close enough, then a write back.
// Every square and the divide by three go through one shared 32x32 multiplier.
// Reset is synchronous and active low; it empties the ring and sets the spacing to 1.0.
// The result is valid, and a new transaction can be taken, in the cycle after the
// write back; a stalled o_result holds one finished result and stalls only the write back.
`default_nettype none
`include "swarm_offset_placer_unit_assert.svh"

module swarm_offset_placer_unit
    import sop_pkg::*;
#(
    parameter int WINDOW = 64
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    sop_in_if.sink               i_item,
    sop_out_if.source            o_result,
    input  wire logic            i_cfg_wr_en,
    input  wire logic [MD_W-1:0] i_cfg_wr_data
);

    localparam int SLOT_W = $clog2(WINDOW);
    localparam int CNT_W  = $clog2(WINDOW + 1);
    localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(WINDOW - 1);
    localparam logic [CNT_W-1:0]  FILL_FULL = CNT_W'(WINDOW);

    t_state                  r_state, n_state;
    logic [MD_W-1:0]         r_spacing, n_spacing;
    logic [2*MD_W-1:0]       r_md2, n_md2;
    logic [MD_W-1:0]         r_step, n_step;
    logic [SLOT_W-1:0]       r_head, n_head;
    logic [CNT_W-1:0]        r_fill, n_fill;
    logic signed [POS_W-1:0] r_last_pos, n_last_pos;
    logic signed [POS_W-1:0] r_y, n_y;
    logic                    r_item_ooo, n_item_ooo;
    logic signed [POS_W-1:0] r_up, n_up;
    logic signed [POS_W-1:0] r_down, n_down;
    logic                    r_side, n_side;
    logic [CNT_W-1:0]        r_k, n_k;
    logic [SLOT_W-1:0]       r_slot, n_slot;
    logic [MD_W-1:0]         r_ady, n_ady;
    logic [2*MD_W-1:0]       r_sqx, n_sqx;
    logic signed [POS_W-1:0] r_chosen, n_chosen;
    logic                    r_out_valid, n_out_valid;
    logic signed [POS_W-1:0] r_x_offset, n_x_offset;
    logic                    r_out_ooo, n_out_ooo;

    logic                    ram_we;
    t_entry                  wr_entry;
    t_entry                  rd_entry;
    logic [MUL_W-1:0]        mul_a;
    logic [MUL_W-1:0]        mul_b;
    logic [PROD_W-1:0]       mul_prod;

    logic signed [POS_W-1:0] cand;
    logic signed [POS_W:0]   dy;
    logic signed [POS_W:0]   dx;
    logic [POS_W:0]          ady;
    logic [POS_W:0]          adx;
    logic [POS_W:0]          md_ext;
    logic                    far_below;
    logic                    near;
    logic [2*MD_W:0]         d2;
    logic                    last_entry;
    logic [SLOT_W-1:0]       slot_prev;
    logic signed [POS_W:0]   up_sum;
    logic signed [POS_W:0]   down_diff;
    logic signed [POS_W-1:0] up_next;
    logic signed [POS_W-1:0] down_next;

    assign wr_entry.pos = r_y;
    assign wr_entry.off = r_chosen;

    sop_ram #(
        .WIDTH ($bits(t_entry)),
        .DEPTH (WINDOW)
    ) u_ring (
        .i_clk     (i_clk),
        .i_wr_en   (ram_we),
        .i_wr_addr (r_head),
        .i_wr_data (wr_entry),
        .i_rd_addr (r_slot),
        .o_rd_data (rd_entry)
    );

    sop_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (mul_a),
        .i_b    (mul_b),
        .o_prod (mul_prod)
    );

    // Distance test of the current candidate against the stored point just read.
    assign cand      = r_side ? r_up : r_down;
    assign dy        = {r_y[POS_W-1], r_y} - {rd_entry.pos[POS_W-1], rd_entry.pos};
    assign dx        = {cand[POS_W-1], cand} - {rd_entry.off[POS_W-1], rd_entry.off};
    assign ady       = dy[POS_W] ? (POS_W+1)'(-dy) : (POS_W+1)'(dy);
    assign adx       = dx[POS_W] ? (POS_W+1)'(-dx) : (POS_W+1)'(dx);
    assign md_ext    = (POS_W+1)'(r_spacing);
    assign far_below = dy > $signed(md_ext);
    assign near      = (ady < md_ext) && (adx < md_ext);
    assign d2        = (2*MD_W+1)'(r_sqx) + (2*MD_W+1)'(mul_prod[2*MD_W-1:0]);

    assign last_entry = (r_k + CNT_W'(1)) == r_fill;
    assign slot_prev  = (r_slot == '0) ? SLOT_LAST : r_slot - SLOT_W'(1);

    // The step is never negative, so only the outward limit can be crossed.
    assign up_sum    = {r_up[POS_W-1], r_up} + (POS_W+1)'(r_step);
    assign down_diff = {r_down[POS_W-1], r_down} - (POS_W+1)'(r_step);
    assign up_next   = (up_sum[POS_W] != up_sum[POS_W-1]) ? OFF_MAX : up_sum[POS_W-1:0];
    assign down_next = (down_diff[POS_W] != down_diff[POS_W-1]) ?
                       OFF_MIN : down_diff[POS_W-1:0];

    always_comb begin
        case (r_state)
            S_MD2: begin
                mul_a = MUL_W'(r_spacing);
                mul_b = MUL_W'(r_spacing);
            end
            S_STEP: begin
                mul_a = MUL_W'(r_spacing);
                mul_b = RECIP3;
            end
            S_CHECK: begin
                mul_a = MUL_W'(adx[MD_W-1:0]);
                mul_b = MUL_W'(adx[MD_W-1:0]);
            end
            S_SQX: begin
                mul_a = MUL_W'(r_ady);
                mul_b = MUL_W'(r_ady);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_comb begin
        n_state     = r_state;
        n_spacing   = r_spacing;
        n_md2       = r_md2;
        n_step      = r_step;
        n_head      = r_head;
        n_fill      = r_fill;
        n_last_pos  = r_last_pos;
        n_y         = r_y;
        n_item_ooo  = r_item_ooo;
        n_up        = r_up;
        n_down      = r_down;
        n_side      = r_side;
        n_k         = r_k;
        n_slot      = r_slot;
        n_ady       = r_ady;
        n_sqx       = r_sqx;
        n_chosen    = r_chosen;
        n_out_valid = r_out_valid;
        n_x_offset  = r_x_offset;
        n_out_ooo   = r_out_ooo;
        ram_we      = 1'b0;

        if (i_cfg_wr_en) begin
            n_spacing = i_cfg_wr_data;
        end
        if (r_out_valid && o_result.ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_item.valid) begin
                    n_y        = i_item.y_pos;
                    n_item_ooo = !i_item.start_req && (r_fill != '0) &&
                                 (i_item.y_pos < r_last_pos);
                    if (i_item.start_req) begin
                        n_head = '0;
                        n_fill = '0;
                    end
                    n_up    = '0;
                    n_down  = '0;
                    n_side  = 1'b0;
                    n_state = S_MD2;
                end
            end
            S_MD2: begin
                n_state = S_STEP;
            end
            S_STEP: begin
                n_md2   = mul_prod[2*MD_W-1:0];
                n_state = S_INIT;
            end
            S_INIT: begin
                n_step  = mul_prod[RECIP3_SHIFT +: MD_W];
                n_state = S_START;
            end
            S_START: begin
                // Walk from the newest stored point toward older ones.
                n_k     = '0;
                n_slot  = (r_head == '0) ? SLOT_LAST : r_head - SLOT_W'(1);
                n_state = (r_fill == '0) ? S_FREE : S_FETCH;
            end
            S_FETCH: begin
                n_state = S_CHECK;
            end
            S_CHECK: begin
                if (far_below) begin
                    n_state = S_FREE;
                end else if (near) begin
                    n_ady   = ady[MD_W-1:0];
                    n_state = S_SQX;
                end else if (last_entry) begin
                    n_state = S_FREE;
                end else begin
                    n_k     = r_k + CNT_W'(1);
                    n_slot  = slot_prev;
                    n_state = S_FETCH;
                end
            end
            S_SQX: begin
                n_sqx   = mul_prod[2*MD_W-1:0];
                n_state = S_SUM;
            end
            S_SUM: begin
                if (d2 < (2*MD_W+1)'(r_md2)) begin
                    n_state = S_BLOCKED;
                end else if (last_entry) begin
                    n_state = S_FREE;
                end else begin
                    n_k     = r_k + CNT_W'(1);
                    n_slot  = slot_prev;
                    n_state = S_FETCH;
                end
            end
            S_FREE: begin
                n_chosen = r_side ? r_up : r_down;
                n_state  = S_WRITE;
            end
            S_BLOCKED: begin
                // The downward candidate is tested first, so it wins a tie.
                if (!r_side) begin
                    n_side  = 1'b1;
                    n_state = S_START;
                end else if ((up_next == r_up) && (down_next == r_down)) begin
                    n_chosen = r_down;
                    n_state  = S_WRITE;
                end else begin
                    n_up    = up_next;
                    n_down  = down_next;
                    n_side  = 1'b0;
                    n_state = S_START;
                end
            end
            S_WRITE: begin
                if (!r_out_valid || o_result.ready) begin
                    ram_we      = 1'b1;
                    n_head      = (r_head == SLOT_LAST) ? '0 : r_head + SLOT_W'(1);
                    n_fill      = (r_fill == FILL_FULL) ? r_fill : r_fill + CNT_W'(1);
                    n_last_pos  = r_y;
                    n_out_valid = 1'b1;
                    n_x_offset  = r_chosen;
                    n_out_ooo   = r_item_ooo;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_spacing   <= SPACING_RESET;
            r_head      <= '0;
            r_fill      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_spacing   <= n_spacing;
            r_head      <= n_head;
            r_fill      <= n_fill;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_md2      <= n_md2;
        r_step     <= n_step;
        r_last_pos <= n_last_pos;
        r_y        <= n_y;
        r_item_ooo <= n_item_ooo;
        r_up       <= n_up;
        r_down     <= n_down;
        r_side     <= n_side;
        r_k        <= n_k;
        r_slot     <= n_slot;
        r_ady      <= n_ady;
        r_sqx      <= n_sqx;
        r_chosen   <= n_chosen;
        r_x_offset <= n_x_offset;
        r_out_ooo  <= n_out_ooo;
    end

    assign i_item.ready          = (r_state == S_IDLE);
    assign o_result.valid        = r_out_valid;
    assign o_result.x_offset     = r_x_offset;
    assign o_result.out_of_order = r_out_ooo;

    `SOP_ASSERT_IMP(a_fill_bounded, 1'b1, r_fill <= FILL_FULL)
    `SOP_ASSERT_IMP(a_walk_in_ring, r_state == S_FETCH, r_k < r_fill)
    `SOP_ASSERT_NEXT(a_accept_starts, i_item.valid && i_item.ready, r_state == S_MD2)
    `SOP_ASSERT_NEXT(a_write_holds, (r_state == S_WRITE) && r_out_valid && !o_result.ready,
                     r_state == S_WRITE)
    `SOP_ASSERT_NEXT(a_write_gives_result, ram_we, r_out_valid && (r_state == S_IDLE))

endmodule

`default_nettype wire

@@ rtl/sop_ram.sv @@
`default_nettype none

module sop_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0]         i_wr_addr,
    input  wire logic [WIDTH-1:0]                 i_wr_data,
    input  wire logic [$clog2(DEPTH)-1:0]         i_rd_addr,
    output logic      [WIDTH-1:0]                 o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

@@ rtl/sop_mul.sv @@
`default_nettype none

module sop_mul
    import sop_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic [MUL_W-1:0]  i_a,
    input  wire logic [MUL_W-1:0]  i_b,
    output logic      [PROD_W-1:0] o_prod
);

    logic [PROD_W-1:0] r_prod;

    // Unsigned product, one result per cycle, registered.
    always_ff @(posedge i_clk) begin
        r_prod <= PROD_W'(i_a) * PROD_W'(i_b);
    end

    assign o_prod = r_prod;

endmodule

`default_nettype wire
